### design/ccl_pkg.sv
// ccl_pkg: operation and status codes for the circular cursor list
// no dependencies; imported by circular_cursor_list
`timescale 1ns / 1ps

package ccl_pkg;

    typedef enum logic [1:0] {
        FUNC_APPEND  = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_ADVANCE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

endpackage

### design/circular_cursor_list.sv
// circular_cursor_list: fixed-capacity circular doubly linked list with a cursor
// depends on ccl_pkg for operation and status codes
//
//  channel | ports                                     | direction
//  s_      | s_valid s_ready s_func s_value            | operation in
//  m_      | m_valid m_ready m_cur_value m_count       | result out
//          | m_is_empty m_status                       |
//
// one operation per cycle sustained while m_ready is high; an operation is captured in
// the input register, then its result in the result register that drives m_valid; the
// whole list update for an operation is done combinationally between those two registers
// a stalled result holds the result register and, behind it, the input register
// synchronous active-low reset empties the list; payload and link stores need no reset
`timescale 1ns / 1ps

module circular_cursor_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic [DATA_WIDTH-1:0]          s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [DATA_WIDTH-1:0]          m_cur_value,
    output logic [$clog2(CAPACITY+1)-1:0]  m_count,
    output logic                           m_is_empty,
    output logic [1:0]                     m_status
);

    import ccl_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    // stores
    logic [DATA_WIDTH-1:0] payload_mem [CAPACITY];
    logic [SW-1:0]         next_mem    [CAPACITY];
    logic [SW-1:0]         prev_mem    [CAPACITY];

    // list state
    logic [CAPACITY-1:0] in_use_reg, in_use_next;
    logic [SW-1:0]       head_reg, head_next;
    logic [SW-1:0]       tail_reg, tail_next;
    logic [SW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       count_reg, count_next;

    // input register
    logic                  in_valid_reg;
    logic [1:0]            func_reg;
    logic [DATA_WIDTH-1:0] value_reg;

    // result register
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] cur_value_reg, cur_value_next;
    logic [CW-1:0]         out_count_reg;
    logic                  is_empty_reg;
    status_t               status_reg, status_next;

    // store write ports
    logic                  pay_we;
    logic [SW-1:0]         pay_addr;
    logic                  nl_we0, nl_we1, pl_we0, pl_we1;
    logic [SW-1:0]         nl_addr0, nl_data0, nl_addr1, nl_data1;
    logic [SW-1:0]         pl_addr0, pl_data0, pl_addr1, pl_data1;

    logic go;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] c_slot, n_slot, p_slot;

    assign go      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || go;

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    assign c_slot = cursor_reg;
    assign n_slot = next_mem[cursor_reg];
    assign p_slot = prev_mem[cursor_reg];

    always_comb begin
        in_use_next = in_use_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        status_next = STAT_DONE;
        pay_we   = 1'b0;
        pay_addr = free_slot;
        nl_we0 = 1'b0; nl_addr0 = '0; nl_data0 = '0;
        nl_we1 = 1'b0; nl_addr1 = '0; nl_data1 = '0;
        pl_we0 = 1'b0; pl_addr0 = '0; pl_data0 = '0;
        pl_we1 = 1'b0; pl_addr1 = '0; pl_data1 = '0;
        unique case (func_reg)
            FUNC_APPEND: begin
                if (count_reg == CW'(CAPACITY)) begin
                    status_next = STAT_FULL;
                end else begin
                    pay_we                 = 1'b1;
                    in_use_next[free_slot] = 1'b1;
                    count_next             = count_reg + 1'b1;
                    tail_next              = free_slot;
                    if (count_reg == '0) begin
                        head_next   = free_slot;
                        cursor_next = free_slot;
                        nl_we0 = 1'b1; nl_addr0 = free_slot; nl_data0 = free_slot;
                        pl_we0 = 1'b1; pl_addr0 = free_slot; pl_data0 = free_slot;
                    end else begin
                        nl_we0 = 1'b1; nl_addr0 = tail_reg;  nl_data0 = free_slot;
                        nl_we1 = 1'b1; nl_addr1 = free_slot; nl_data1 = head_reg;
                        pl_we0 = 1'b1; pl_addr0 = free_slot; pl_data0 = tail_reg;
                        pl_we1 = 1'b1; pl_addr1 = head_reg;  pl_data1 = free_slot;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (count_reg == '0) begin
                    status_next = STAT_EMPTY;
                end else begin
                    in_use_next[c_slot] = 1'b0;
                    count_next          = count_reg - 1'b1;
                    if (count_reg == CW'(1)) begin
                        head_next   = '0;
                        tail_next   = '0;
                        cursor_next = '0;
                    end else begin
                        nl_we0 = 1'b1; nl_addr0 = p_slot; nl_data0 = n_slot;
                        pl_we0 = 1'b1; pl_addr0 = n_slot; pl_data0 = p_slot;
                        if (c_slot == head_reg) begin
                            head_next = n_slot;
                        end
                        if (c_slot == tail_reg) begin
                            tail_next = p_slot;
                        end
                        cursor_next = n_slot;
                    end
                end
            end
            FUNC_ADVANCE: begin
                if (count_reg == '0) begin
                    status_next = STAT_EMPTY;
                end else begin
                    cursor_next = n_slot;
                end
            end
            default: begin
                // unused code: report current list
            end
        endcase

        if (count_next == '0) begin
            cur_value_next = '0;
        end else if (pay_we && (count_reg == '0)) begin
            cur_value_next = value_reg;
        end else begin
            cur_value_next = payload_mem[cursor_next];
        end
    end

    // stores
    always_ff @(posedge aclk) begin
        if (go) begin
            if (pay_we) begin
                payload_mem[pay_addr] <= value_reg;
            end
            if (nl_we0) begin
                next_mem[nl_addr0] <= nl_data0;
            end
            if (nl_we1) begin
                next_mem[nl_addr1] <= nl_data1;
            end
            if (pl_we0) begin
                prev_mem[pl_addr0] <= pl_data0;
            end
            if (pl_we1) begin
                prev_mem[pl_addr1] <= pl_data1;
            end
        end
    end

    // control and list state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_use_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cursor_reg    <= '0;
            count_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (go) begin
                out_valid_reg <= 1'b1;
                in_use_reg    <= in_use_next;
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                cursor_reg    <= cursor_next;
                count_reg     <= count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= s_func;
            value_reg <= s_value;
        end
        if (go) begin
            cur_value_reg <= cur_value_next;
            out_count_reg <= count_next;
            is_empty_reg  <= (count_next == '0);
            status_reg    <= status_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_cur_value = cur_value_reg;
    assign m_count     = out_count_reg;
    assign m_is_empty  = is_empty_reg;
    assign m_status    = status_reg;

endmodule
